@@ hw/rtl/swa_pkg.sv @@
// ----------------------------------------------------------------------------
// swa_pkg: shared definitions for the sliding window averager
// Data width, default window depth and the sequencer state encoding.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned WINDOW_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for an input transaction
    ST_UPDATE,  // ring store write, fill count and running sum update
    ST_PREP,    // load divider with |sum|
    ST_DIV,     // one restoring divide step per cycle
    ST_DONE     // sign fix, hand result to output register
  } state_t;

endpackage

@@ hw/rtl/sliding_window_averager_core.sv @@
// ----------------------------------------------------------------------------
// sliding_window_averager_core: moving average over the last WINDOW samples
// Ring store, fill count, running sum and a shared restoring divider.
// ----------------------------------------------------------------------------
// Each input transaction either clears the window (in_clear = 1) or pushes
// in_sample; a push into a full window drops the oldest sample. Every input
// transaction yields exactly one result transaction: the held-sample count,
// an empty flag and the mean (sum / count, truncated toward zero, 0 when
// empty). After acceptance an item goes through the ring store update, the
// divider load, the one-bit-per-cycle restoring divider, and a final step
// that fixes the sign and loads the output register; a busy output register
// stalls that final step. The sequencer then returns to idle before it
// takes the next transaction, so a new input is taken only after the last
// result is loaded. in_ready is high only while the sequencer is idle; a
// finished result may wait in the output register while the next input
// transaction is taken. The ring store needs no clearing after reset:
// entries are read only after being written.
// ----------------------------------------------------------------------------
module sliding_window_averager_core #(
  parameter  int unsigned WINDOW = swa_pkg::WINDOW_DEF,
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [swa_pkg::DATA_W-1:0] in_sample,
  input  logic                      in_clear,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [swa_pkg::DATA_W-1:0] out_average,
  output logic [CNT_W-1:0]          out_count,
  output logic                      out_empty_res
);

  import swa_pkg::*;

  // Sum range is +/- WINDOW * 2^15, so DATA_W + log2(WINDOW) bits suffice.
  localparam int unsigned SUM_W  = DATA_W + $clog2(WINDOW);
  localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned ITER_W = $clog2(SUM_W);

  // --------------------------------------------------------------------------
  // Sequencer and architectural state
  // --------------------------------------------------------------------------
  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           fill_count_r, fill_count_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [PTR_W-1:0]           oldest_r, oldest_nxt;

  // captured input transaction
  logic signed [DATA_W-1:0]   sample_r;
  logic                       clear_r;

  // ring store (memory, one write and one registered read port)
  logic [DATA_W-1:0]          store_mem [WINDOW];
  logic [DATA_W-1:0]          rd_data_r;
  logic [PTR_W-1:0]           slot_idx;
  logic                       store_we;

  // divider
  logic [CNT_W-1:0]           rem_r, rem_nxt;
  logic [SUM_W-1:0]           quo_r, quo_nxt;
  logic [ITER_W-1:0]          iter_r, iter_nxt;
  logic                       neg_r, neg_nxt;
  logic [CNT_W:0]             trial;
  logic [CNT_W:0]             diff;
  logic                       ge;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0]   out_average_r;
  logic [CNT_W-1:0]           out_count_r;
  logic                       out_empty_res_r;
  logic                       out_load;
  logic [SUM_W-1:0]           avg_full;

  logic                       in_fire;
  logic                       full;
  logic [CNT_W:0]             idx_sum;
  logic signed [SUM_W-1:0]    sample_ext, old_ext;

  assign in_fire = in_valid && in_ready;
  assign full    = (fill_count_r == CNT_W'(WINDOW));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_DIV;
      ST_DIV:    if (iter_r == '0) state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    store_we = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_UPDATE: store_we = !clear_r;
      ST_PREP:   ;
      ST_DIV:    ;
      // output register is free, or its result leaves this cycle
      ST_DONE:   out_load = !out_valid_r || out_ready;
      default:   ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Ring store addressing and running sum update
  // --------------------------------------------------------------------------
  // oldest + count is below 2*WINDOW, one compare-subtract wraps it.
  always_comb begin
    idx_sum = (CNT_W+1)'(oldest_r) + (CNT_W+1)'(fill_count_r);
    if (idx_sum >= (CNT_W+1)'(WINDOW)) begin
      idx_sum = idx_sum - (CNT_W+1)'(WINDOW);
    end
    slot_idx = full ? oldest_r : idx_sum[PTR_W-1:0];
  end

  assign sample_ext = SUM_W'(sample_r);
  assign old_ext    = SUM_W'($signed(rd_data_r));

  always_comb begin
    fill_count_nxt = fill_count_r;
    sum_nxt        = sum_r;
    oldest_nxt     = oldest_r;
    if (state_r == ST_UPDATE) begin
      if (clear_r) begin
        fill_count_nxt = '0;
        sum_nxt        = '0;
        oldest_nxt     = '0;
      end else if (full) begin
        // intermediate wrap cancels out, the final sum is in range
        sum_nxt    = sum_r + sample_ext - old_ext;
        oldest_nxt = (oldest_r == PTR_W'(WINDOW - 1)) ? '0 : oldest_r + 1'b1;
      end else begin
        sum_nxt        = sum_r + sample_ext;
        fill_count_nxt = fill_count_r + 1'b1;
      end
    end
  end

  // Store: read of the oldest entry issued at acceptance, used in ST_UPDATE.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= store_mem[oldest_r];
    end
    if (store_we) begin
      store_mem[slot_idx] <= sample_r;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider: |sum| / count, one quotient bit per cycle
  // --------------------------------------------------------------------------
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign diff  = trial - {1'b0, fill_count_r};
  assign ge    = (trial >= {1'b0, fill_count_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    iter_nxt = iter_r;
    neg_nxt  = neg_r;
    case (state_r)
      ST_PREP: begin
        neg_nxt  = sum_r[SUM_W-1];
        quo_nxt  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
        rem_nxt  = '0;
        iter_nxt = ITER_W'(SUM_W - 1);
      end
      ST_DIV: begin
        rem_nxt  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_nxt  = {quo_r[SUM_W-2:0], ge};
        iter_nxt = iter_r - 1'b1;
      end
      default: ;
    endcase
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign avg_full = neg_r ? (~quo_r + 1'b1) : quo_r;

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_count_r <= '0;
      sum_r        <= '0;
      oldest_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      sum_r        <= sum_nxt;
      oldest_r     <= oldest_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_sample;
      clear_r  <= in_clear;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    iter_r <= iter_nxt;
    neg_r  <= neg_nxt;
    if (out_load) begin
      out_average_r   <= (fill_count_r == '0) ? '0 : DATA_W'(avg_full);
      out_count_r     <= fill_count_r;
      out_empty_res_r <= (fill_count_r == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_average   = out_average_r;
  assign out_count     = out_count_r;
  assign out_empty_res = out_empty_res_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNT_W'(WINDOW))
    else $error("fill count beyond window depth");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_count_r == '0) |-> (sum_r == '0))
    else $error("running sum nonzero with empty window");

  a_fire_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_UPDATE))
    else $error("accepted transaction did not start an update");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_res_r == (out_count_r == '0)))
    else $error("empty flag disagrees with count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ready) |=> (state_r == ST_DONE))
    else $error("result dropped while output register busy");

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sliding_window_averager_core
// Drives push and clear transactions with random gaps and back-pressure, and
// predicts the held-sample mean, count and empty flag of every transaction.
// ----------------------------------------------------------------------------
module testbench;

  import swa_pkg::*;

  localparam int unsigned WIN_DEPTH = WINDOW_DEF;
  localparam int unsigned CNT_BITS  = $clog2(WIN_DEPTH + 1);

  // Gap rate is in percent per cycle on each side.
  localparam int unsigned GAP_PCT      = 24;
  // Sender and receiver both run gap-free between these transaction counts.
  localparam int unsigned QUIET_LO     = 500;
  localparam int unsigned QUIET_HI     = 700;
  // One long receiver hold-off, so the output register fills and in_ready drops.
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_LEN     = 400;
  localparam int unsigned RANDOM_ITEMS = 1400;
  // Drain wait after the last result.
  localparam int unsigned DRAIN_CYC    = 100;
  localparam int unsigned LIMIT_CYC    = 600000;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     clear;
  } window_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] average;
    logic [CNT_BITS-1:0]      count;
    logic                     empty_res;
  } mean_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_sample = '0;
  logic                     in_clear = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_average;
  logic [CNT_BITS-1:0]      out_count;
  logic                     out_empty_res;

  window_item_t pending_items[$];
  mean_result_t expected_means[$];
  int unsigned  err_count     = 0;
  int unsigned  sent_count    = 0;
  int unsigned  results_seen  = 0;
  int unsigned  hold_left     = 0;

  // Predictor state: ring of held samples, fill count, running sum, oldest slot.
  logic signed [DATA_W-1:0] win_buf [WIN_DEPTH];
  logic [CNT_BITS-1:0]      win_fill = '0;
  logic signed [19:0]       win_sum  = '0;
  logic [3:0]               win_head = '0;

  sliding_window_averager_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_clear      (in_clear),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_average   (out_average),
    .out_count     (out_count),
    .out_empty_res (out_empty_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted transaction to the window and queue its mean.
  task automatic update_window_mean(input logic signed [DATA_W-1:0] smp, input logic clr);
    mean_result_t r;
    logic [3:0]   slot;
    int           quot;
    if (clr) begin
      win_fill = '0;
      win_sum  = '0;
      win_head = '0;
    end else begin
      if (win_fill == WIN_DEPTH) begin
        // full: oldest sample leaves the sum, its slot takes the new one
        win_sum           = win_sum - win_buf[win_head];
        win_buf[win_head] = smp;
        win_head          = win_head + 4'd1;
      end else begin
        slot          = win_head + win_fill[3:0];
        win_buf[slot] = smp;
        win_fill      = win_fill + 1'b1;
      end
      win_sum = win_sum + smp;
    end
    quot = 0;
    if (win_fill != 0) quot = int'(win_sum) / int'(win_fill);  // truncates toward zero
    r.average   = quot[DATA_W-1:0];
    r.count     = win_fill;
    r.empty_res = (win_fill == 0);
    expected_means.push_back(r);
  endtask

  // Sample value by flavor: full range, pinned near max, pinned near min, small.
  function automatic logic signed [DATA_W-1:0] pick_sample(input int unsigned flavor);
    logic signed [DATA_W-1:0] v;
    v = DATA_W'($urandom);
    case (flavor)
      1: begin
        if ($urandom_range(0, 3) != 0) v = 16'sh7FFF;
        else v = 16'sh7FFF - $signed(16'($urandom_range(0, 15)));
      end
      2: begin
        if ($urandom_range(0, 3) != 0) v = -16'sh8000;
        else v = -16'sh8000 + $signed(16'($urandom_range(0, 15)));
      end
      3: v = $signed(16'($urandom_range(0, 15))) - 16'sd8;
      default: ;
    endcase
    return v;
  endfunction

  // Driver: offers the next pending transaction, holds it until accepted.
  always @(posedge clk) begin : drv_proc
    logic         fire;
    logic         gap;
    window_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        update_window_mean(in_sample, in_clear);
        sent_count++;
      end
      if (!(in_valid && !fire)) begin
        gap = (sent_count < QUIET_LO || sent_count >= QUIET_HI) &&
              ($urandom_range(0, 99) < GAP_PCT);
        if (pending_items.size() != 0 && !gap) begin
          nxt = pending_items.pop_front();
          in_sample <= nxt.sample;
          in_clear  <= nxt.clear;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expected mean
  // and drives out_ready with random stalls plus one long hold-off.
  always @(posedge clk) begin : mon_proc
    mean_result_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_means.size() == 0) begin
          $error("unexpected result: average=%0d count=%0d empty_res=%0b",
                 out_average, out_count, out_empty_res);
          err_count++;
        end else begin
          exp_r = expected_means.pop_front();
          if (out_average !== exp_r.average) begin
            $error("average: expected %0d, got %0d", exp_r.average, out_average);
            err_count++;
          end
          if (out_count !== exp_r.count) begin
            $error("count: expected %0d, got %0d", exp_r.count, out_count);
            err_count++;
          end
          if (out_empty_res !== exp_r.empty_res) begin
            $error("empty_res: expected %0b, got %0b", exp_r.empty_res, out_empty_res);
            err_count++;
          end
        end
        results_seen++;
        if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= QUIET_LO && results_seen < QUIET_HI) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= GAP_PCT);
      end
    end
  end

  initial begin : stim_proc
    window_item_t it;
    int unsigned  total;
    int unsigned  run_len;
    int unsigned  flavor;

    // Directed: clear on an empty window, extremes with truncation toward
    // zero, then fill to full with max values and push past full.
    it.clear = 1'b1; it.sample = DATA_W'($urandom); pending_items.push_back(it);
    it.clear = 1'b0; it.sample = -16'sh8000;     pending_items.push_back(it);
    it.sample = 16'sh7FFF;                        pending_items.push_back(it);
    it.sample = -16'sd1;                          pending_items.push_back(it);
    it.clear = 1'b1; it.sample = ~16'sd0;        pending_items.push_back(it);
    it.clear = 1'b0;
    for (int i = 0; i < 17; i++) begin
      it.sample = 16'sh7FFF;
      pending_items.push_back(it);
    end
    for (int i = 0; i < 3; i++) begin
      it.sample = -16'sh8000;
      pending_items.push_back(it);
    end

    // Random: runs of pushes with one value flavor, usually long enough to
    // wrap the window, sometimes opened by a clear.
    total = 0;
    while (total < RANDOM_ITEMS) begin
      flavor  = $urandom_range(0, 3);
      run_len = $urandom_range(1, 60);
      if ($urandom_range(0, 1) == 0) begin
        it.clear  = 1'b1;
        it.sample = DATA_W'($urandom);
        pending_items.push_back(it);
        total++;
      end
      for (int i = 0; i < run_len; i++) begin
        it.clear = ($urandom_range(0, 99) < 2);
        it.sample = pick_sample(flavor);
        pending_items.push_back(it);
        total++;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : limit_proc
    #(LIMIT_CYC * 10);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sliding_window_averager_core.f @@
hw/rtl/swa_pkg.sv
hw/rtl/sliding_window_averager_core.sv
test/testbench.sv
